/* rtl/ordered_list_store_assert.svh */
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define OLST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define OLST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/olst_pkg.sv */
package olst_pkg;

   localparam int DEPTH_DEF      = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W      = 3;
   localparam int POS_W     = 9;
   localparam int VAL_W     = 32;
   localparam int DOUT_W    = 32;
   localparam int FPOS_W    = 8;
   localparam int STAT_W    = 3;
   localparam int COUNT_W   = 9;

   localparam int REQ_OP_LSB  = 0;
   localparam int REQ_POS_LSB = REQ_OP_LSB + OP_W;
   localparam int REQ_VAL_LSB = REQ_POS_LSB + POS_W;
   localparam int REQ_USED_W  = REQ_VAL_LSB + VAL_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_DOUT_LSB  = 0;
   localparam int RSP_FPOS_LSB  = RSP_DOUT_LSB + DOUT_W;
   localparam int RSP_STAT_LSB  = RSP_FPOS_LSB + FPOS_W;
   localparam int RSP_COUNT_LSB = RSP_STAT_LSB + STAT_W;
   localparam int RSP_EMPTY_LSB = RSP_COUNT_LSB + COUNT_W;
   localparam int RSP_USED_W    = RSP_EMPTY_LSB + 1;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_POP_LAST = 3'd1,
      OP_POP_AT   = 3'd2,
      OP_INSERT   = 3'd3,
      OP_DELETE   = 3'd4,
      OP_WRITE    = 3'd5,
      OP_READ     = 3'd6,
      OP_FIND     = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_BOUNDS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_SHIFT_L,
      S_SHIFT_R,
      S_PLACE,
      S_FIND,
      S_DONE
   } state_type;

endpackage

/* rtl/olst_ram.sv */
module olst_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ordered_list_store.sv */
// Ordered list of signed words kept in one simple dual-port RAM (one write
// port, one read port, registered read data). One request is worked on at a
// time; a finished result sits in an output register, so the next request
// is taken while it waits. Append and write go from the check state to the
// result; read and pop last pass through one RAM read first. Pop at, delete,
// insert and find walk the RAM one word per cycle through its read port:
// pop at, delete and insert move the words past the position, find scans
// from word 0 to a match or the list's end. The fill count lives in a
// register and bounds every read, so no clearing pass is needed after reset.
module ordered_list_store
   import olst_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op[2:0], position[11:3], value[43:12], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // data_out[31:0], found_position[39:32], status[42:40], count[51:43],
   // is_empty[52], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] word_ff, word_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [FPOS_W-1:0]     found_ff, found_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

   logic                  req_fire, rsp_load, full, pos_eq_n, ptr_at_pos;
   logic [CMP_W-1:0]      pos_ext, n_ext;
   logic [ADDR_W-1:0]     pos_addr, n_addr, last_addr, ptr_inc, ptr_dec;
   logic [CNT_W-1:0]      n_dec, ptr_ext;
   status_type            chk_status;

   olst_ram #(
      .DEPTH(DEPTH),
      .WIDTH(DATA_WIDTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_load   = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_tready);

   assign pos_ext    = CMP_W'(pos_ff);
   assign n_ext      = CMP_W'(n_ff);
   assign pos_addr   = pos_ext[ADDR_W-1:0];
   assign n_addr     = n_ff[ADDR_W-1:0];
   assign n_dec      = n_ff - CNT_W'(1);
   assign last_addr  = n_dec[ADDR_W-1:0];
   assign ptr_inc    = ptr_ff + ADDR_W'(1);
   assign ptr_dec    = ptr_ff - ADDR_W'(1);
   assign ptr_ext    = CNT_W'(ptr_ff);
   assign full       = (n_ff == CNT_W'(DEPTH));
   assign pos_eq_n   = (pos_ext == n_ext);
   assign ptr_at_pos = (ptr_ff == pos_addr);

   always_comb begin
      chk_status = ST_OK;
      unique case (op_ff) inside
         OP_APPEND: begin
            if (full) chk_status = ST_FULL;
         end
         OP_POP_LAST: begin
            if (n_ff == '0) chk_status = ST_EMPTY;
         end
         OP_POP_AT, OP_DELETE, OP_WRITE, OP_READ: begin
            if (pos_ext >= n_ext) chk_status = ST_BOUNDS;
         end
         OP_INSERT: begin
            if (full) chk_status = ST_FULL;
            else if (pos_ext > n_ext) chk_status = ST_BOUNDS;
         end
         OP_FIND: begin
            if (n_ff == '0) chk_status = ST_NOTFOUND;
         end
         default: chk_status = ST_OK;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (chk_status != ST_OK) begin
               state_in = S_DONE;
            end else begin
               unique case (op_ff) inside
                  OP_APPEND, OP_WRITE:   state_in = S_DONE;
                  OP_POP_LAST, OP_READ:  state_in = S_READ;
                  OP_POP_AT, OP_DELETE:  state_in = S_SHIFT_L;
                  OP_INSERT:             state_in = pos_eq_n ? S_DONE : S_SHIFT_R;
                  OP_FIND:               state_in = S_FIND;
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_READ: state_in = S_DONE;
         S_SHIFT_L: begin
            if (ptr_ext == n_ff) state_in = S_DONE;
         end
         S_SHIFT_R: begin
            if (ptr_at_pos) state_in = S_PLACE;
         end
         S_PLACE: state_in = S_DONE;
         S_FIND: begin
            if ((mem_rdata == word_ff) || (ptr_ext + CNT_W'(1) == n_ff)) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      data_in      = data_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_inc;
      mem_wdata    = word_ff;
      mem_re       = 1'b0;
      mem_raddr    = ptr_inc;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = op_type'(req_tdata[REQ_OP_LSB +: OP_W]);
               pos_in    = req_tdata[REQ_POS_LSB +: POS_W];
               word_in   = DATA_WIDTH'(signed'(req_tdata[REQ_VAL_LSB +: VAL_W]));
               data_in   = '0;
               found_in  = '0;
               status_in = ST_OK;
            end
         end
         S_CHECK: begin
            status_in = chk_status;
            if (chk_status == ST_OK) begin
               unique case (op_ff) inside
                  OP_APPEND: begin
                     mem_we    = 1'b1;
                     mem_waddr = n_addr;
                     n_in      = n_ff + CNT_W'(1);
                  end
                  OP_POP_LAST: begin
                     mem_re    = 1'b1;
                     mem_raddr = last_addr;
                     n_in      = n_dec;
                  end
                  OP_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = pos_addr;
                  end
                  OP_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_addr;
                  end
                  OP_POP_AT, OP_DELETE: begin
                     mem_re    = 1'b1;
                     mem_raddr = pos_addr;
                     ptr_in    = pos_addr;
                     n_in      = n_dec;
                  end
                  OP_INSERT: begin
                     n_in = n_ff + CNT_W'(1);
                     if (pos_eq_n) begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_addr;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = last_addr;
                        ptr_in    = last_addr;
                     end
                  end
                  OP_FIND: begin
                     mem_re    = 1'b1;
                     mem_raddr = '0;
                     ptr_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: data_in = mem_rdata;
         S_SHIFT_L: begin
            if (!ptr_at_pos) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_dec;
               mem_wdata = mem_rdata;
            end else if (op_ff == OP_POP_AT) begin
               data_in = mem_rdata;
            end
            if (ptr_ext != n_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_inc;
               ptr_in    = ptr_inc;
            end
         end
         S_SHIFT_R: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_inc;
            mem_wdata = mem_rdata;
            if (!ptr_at_pos) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_dec;
               ptr_in    = ptr_dec;
            end
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_addr;
         end
         S_FIND: begin
            if (mem_rdata == word_ff) begin
               found_in = FPOS_W'(ptr_ff);
            end else if (ptr_ext + CNT_W'(1) == n_ff) begin
               status_in = ST_NOTFOUND;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_inc;
               ptr_in    = ptr_inc;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = RSP_TDATA_W'({(n_ff == '0), COUNT_W'(n_ff), status_ff,
                                            found_ff, DOUT_W'(signed'(data_ff))});
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      word_ff      <= word_in;
      ptr_ff       <= ptr_in;
      data_ff      <= data_in;
      found_ff     <= found_in;
      status_ff    <= status_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* rtl/olst_checker.sv */
`include "ordered_list_store_assert.svh"

module olst_checker
   import olst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [1:0] pend_ff, pend_in;
   logic       req_xfer, rsp_xfer;
   logic [STAT_W-1:0]  rsp_status;
   logic [COUNT_W-1:0] rsp_count;

   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_xfer   = rsp_tvalid & rsp_tready;
   assign rsp_status = rsp_tdata[RSP_STAT_LSB +: STAT_W];
   assign rsp_count  = rsp_tdata[RSP_COUNT_LSB +: COUNT_W];

   // requests taken minus results delivered
   always_comb begin
      pend_in = pend_ff;
      if (req_xfer && !rsp_xfer) pend_in = pend_ff + 2'd1;
      else if (!req_xfer && rsp_xfer) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `OLST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `OLST_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_tvalid, pend_ff != 2'd0,
      "result without a request")
   `OLST_ASSERT_NOW(a_pend_bound, clock, reset, 1'b1, pend_ff != 2'd3,
      "more than two requests in flight")
   `OLST_ASSERT_NOW(a_err_zero, clock, reset, rsp_tvalid && (rsp_status != ST_OK),
      (rsp_tdata[RSP_DOUT_LSB +: DOUT_W] == '0) && (rsp_tdata[RSP_FPOS_LSB +: FPOS_W] == '0),
      "failed request returned data")
   `OLST_ASSERT_NOW(a_empty_flag, clock, reset, rsp_tvalid,
      rsp_tdata[RSP_EMPTY_LSB] == (rsp_count == '0), "empty flag disagrees with count")

endmodule

bind ordered_list_store olst_checker u_olst_checker (.*);
